[hw/rtl/ascon_hash_xof_sponge_top_defines.svh]
// Assertion macros shared by the sponge RTL files.
// No dependencies; included by the modules that carry assertions.
`ifndef ASCON_HASH_XOF_SPONGE_TOP_DEFINES_SVH
`define ASCON_HASH_XOF_SPONGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHX_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sponge assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sponge assertion failed");

`endif

[hw/rtl/ahx_pkg.sv]
// Types, constants and the round function of the Ascon hash/XOF sponge.
// No dependencies; used by every module of the block.
package ahx_pkg;

    localparam int LANE_W           = 64;
    localparam int CNT_W            = 4;
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 64;
    localparam int CFG_W            = 6;
    localparam int MAX_OUT_WORDS_DEF = 32;
    localparam int Q_DEPTH          = 2;

    localparam logic [7:0] RC_FULL = 8'hf0;
    localparam logic [7:0] RC_HALF = 8'hb4;
    localparam logic [7:0] RC_LAST = 8'h4b;
    localparam logic [7:0] RC_STEP = 8'h0f;

    localparam logic [7:0]        PAD_BYTE = 8'h80;
    localparam logic [LANE_W-1:0] PAD_WORD = 64'h8000_0000_0000_0000;

    localparam logic [CFG_W-1:0] OUT_WORDS_RST = 6'd4;
    localparam logic [1:0]       VARIANT_RST   = 2'd0;

    typedef enum logic {
        CFG_VARIANT   = 1'b0,
        CFG_OUT_WORDS = 1'b1
    } ahx_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_IDLE,
        ST_ABS,
        ST_FIN,
        ST_OUT,
        ST_SQZ
    } ahx_state_e_t;

    typedef logic [4:0][LANE_W-1:0] ahx_lanes_t;

    typedef struct packed {
        logic              final_blk;
        logic [LANE_W-1:0] word;
    } ahx_qent_t;

    function automatic logic [LANE_W-1:0] ahx_rotr(logic [LANE_W-1:0] x, int unsigned n);
        return (x >> n) | (x << (LANE_W - n));
    endfunction

    function automatic ahx_lanes_t ahx_round(ahx_lanes_t s, logic [7:0] rc);
        logic [LANE_W-1:0] x0, x1, x2, x3, x4;
        logic [LANE_W-1:0] t0, t1, t2, t3, t4;
        ahx_lanes_t r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {{(LANE_W-8){1'b0}}, rc};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ ahx_rotr(x0, 19) ^ ahx_rotr(x0, 28);
        r[1] = x1 ^ ahx_rotr(x1, 61) ^ ahx_rotr(x1, 39);
        r[2] = x2 ^ ahx_rotr(x2, 1) ^ ahx_rotr(x2, 6);
        r[3] = x3 ^ ahx_rotr(x3, 10) ^ ahx_rotr(x3, 17);
        r[4] = x4 ^ ahx_rotr(x4, 7) ^ ahx_rotr(x4, 41);
        return r;
    endfunction

    function automatic ahx_lanes_t ahx_iv(logic [1:0] variant);
        ahx_lanes_t s;
        s    = '0;
        s[0] = 64'h0040_0c00_0000_0000;
        if (variant[0]) begin
            s[0] = s[0] | 64'h0000_0004_0000_0000;
        end
        if (!variant[1]) begin
            s[0] = s[0] | 64'h0000_0000_0000_0100;
        end
        return s;
    endfunction

    function automatic logic [7:0] ahx_rc_start(logic [1:0] variant);
        return variant[0] ? RC_HALF : RC_FULL;
    endfunction

endpackage

[hw/rtl/ascon_hash_xof_sponge_top.sv]
// Ascon hash/XOF sponge: a front that takes message words, a short queue, and a
// permutation engine that absorbs and squeezes. Depends on ahx_pkg, ahx_front,
// ahx_queue and ahx_engine.
//
// Usage: the s_ channel carries one 64-bit big-endian message word per transfer
// with its byte count; s_tlast marks the final word (0 to 7 bytes, or 8 for a full
// final word). The m_ channel returns the digest words, m_tlast on the last one.
// cfg_we writes register cfg_index: 0 selects the variant (hash, hasha, xof, xofa)
// and restarts the sponge, 1 sets the number of output words.
// Operation: every absorbed word costs one permutation, one round per cycle in the
// single round unit; hasha/xofa start absorb and squeeze permutations at a later
// round constant than hash/xof. A full final word costs one extra permutation, a
// plain absorb before a padding-only final entry. The final permutation, one per
// further digest word and the initial-state permutation follow before the next
// message is absorbed. Two queued words let the sender run ahead of the engine.
// Reset: the sponge builds the hash initial state; words are queued meanwhile. A stalled
// receiver holds the output register; the engine waits with the next word ready and the
// input side keeps filling the queue.
module ascon_hash_xof_sponge_top #(
    parameter int MAX_OUT_WORDS = ahx_pkg::MAX_OUT_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ahx_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ahx_pkg::S_TDATA_W-1:0] s_tdata,   // msg_block[63:0], byte_count[67:64], zeros
    input  logic                          s_tlast,   // last_block
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ahx_pkg::M_TDATA_W-1:0] m_tdata,   // digest_word[63:0]
    output logic                          m_tlast    // last_word
);

    logic               q_room;
    logic               q_push;
    ahx_pkg::ahx_qent_t q_entry;
    logic               q_valid;
    ahx_pkg::ahx_qent_t q_head;
    logic               q_pop;

    ahx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_room   (q_room),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    ahx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .room       (q_room),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    ahx_engine #(
        .MAX_OUT_WORDS (MAX_OUT_WORDS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[hw/rtl/ahx_front.sv]
// Input side of the sponge: accepts message words and turns them into queue entries.
// Depends on ahx_pkg for the queue entry type and padding constants.
module ahx_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ahx_pkg::S_TDATA_W-1:0] s_tdata,   // msg_block[63:0], byte_count[67:64], zeros
    input  logic                          s_tlast,
    input  logic                          q_room,
    output logic                          q_push,
    output ahx_pkg::ahx_qent_t            q_entry
);

    logic                          pend_reg;
    logic                          pend_next;
    logic [ahx_pkg::LANE_W-1:0]    blk;
    logic [ahx_pkg::CNT_W-1:0]     cnt;
    logic [ahx_pkg::LANE_W-1:0]    padded;
    logic                          accept;

    assign blk      = s_tdata[ahx_pkg::LANE_W-1:0];
    assign cnt      = s_tdata[ahx_pkg::LANE_W +: ahx_pkg::CNT_W];
    assign s_tready = !pend_reg && q_room;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (ahx_pkg::CNT_W'(i) < cnt) begin
                padded[ahx_pkg::LANE_W-1-8*i -: 8] = blk[ahx_pkg::LANE_W-1-8*i -: 8];
            end else if (ahx_pkg::CNT_W'(i) == cnt) begin
                padded[ahx_pkg::LANE_W-1-8*i -: 8] = ahx_pkg::PAD_BYTE;
            end else begin
                padded[ahx_pkg::LANE_W-1-8*i -: 8] = 8'h00;
            end
        end
    end

    // A full final word goes out as a plain absorb followed by a padding-only final entry.
    always_comb begin
        q_push    = 1'b0;
        q_entry   = '0;
        pend_next = pend_reg;
        if (pend_reg) begin
            q_push            = q_room;
            q_entry.final_blk = 1'b1;
            q_entry.word      = ahx_pkg::PAD_WORD;
            if (q_room) begin
                pend_next = 1'b0;
            end
        end else if (accept) begin
            q_push = 1'b1;
            if (!s_tlast || cnt[ahx_pkg::CNT_W-1]) begin
                q_entry.final_blk = 1'b0;
                q_entry.word      = blk;
                pend_next         = s_tlast;
            end else begin
                q_entry.final_blk = 1'b1;
                q_entry.word      = padded;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

endmodule

[hw/rtl/ahx_queue.sv]
// Short first-in first-out queue between the front and the permutation engine.
// Depends on ahx_pkg for the entry type and depth; includes the assertion macros.
`include "ascon_hash_xof_sponge_top_defines.svh"

module ahx_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ahx_pkg::ahx_qent_t push_entry,
    output logic               room,
    output logic               head_valid,
    output ahx_pkg::ahx_qent_t head_entry,
    input  logic               pop
);

    localparam int PW = $clog2(ahx_pkg::Q_DEPTH);
    localparam int CW = $clog2(ahx_pkg::Q_DEPTH + 1);

    ahx_pkg::ahx_qent_t slot_reg [ahx_pkg::Q_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               do_push;
    logic               do_pop;

    assign room       = count_reg != CW'(ahx_pkg::Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && room;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(ahx_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(ahx_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `AHX_ASSERT_NOW(a_queue_no_overflow, aclk, aresetn, push, room)

endmodule

[hw/rtl/ahx_engine.sv]
// Permutation engine: one Ascon round per cycle while permuting; absorb, squeeze and reinitialization.
// Depends on ahx_pkg for the round function and state types; includes the assertion macros.
`include "ascon_hash_xof_sponge_top_defines.svh"

module ahx_engine #(
    parameter int MAX_OUT_WORDS = ahx_pkg::MAX_OUT_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ahx_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          q_valid,
    input  ahx_pkg::ahx_qent_t            q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ahx_pkg::M_TDATA_W-1:0] m_tdata,   // digest_word[63:0]
    output logic                          m_tlast
);

    localparam int NW = $clog2(MAX_OUT_WORDS + 1);

    ahx_pkg::ahx_state_e_t      st_reg;
    ahx_pkg::ahx_state_e_t      st_next;
    ahx_pkg::ahx_lanes_t        lanes_reg;
    ahx_pkg::ahx_lanes_t        lanes_next;
    ahx_pkg::ahx_lanes_t        round_in;
    ahx_pkg::ahx_lanes_t        round_out;
    logic [7:0]                 rc_reg;
    logic [7:0]                 rc_next;
    logic [7:0]                 rc_in;
    logic [NW-1:0]              idx_reg;
    logic [NW-1:0]              idx_next;
    logic [NW-1:0]              n_reg;
    logic [NW-1:0]              n_next;
    logic [NW-1:0]              n_clamped;
    logic [1:0]                 variant_reg;
    logic [ahx_pkg::CFG_W-1:0]  out_words_reg;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [ahx_pkg::LANE_W-1:0] m_data_reg;
    logic                       m_last_reg;
    logic                       out_free;
    logic                       out_load;
    logic                       is_last;
    logic                       rc_done;
    logic                       variant_wr;

    assign round_out  = ahx_pkg::ahx_round(round_in, rc_in);
    assign out_free   = !m_valid_reg || m_tready;
    assign is_last    = idx_reg == n_reg - 1'b1;
    assign rc_done    = rc_reg == ahx_pkg::RC_LAST;
    assign variant_wr = cfg_we && (cfg_index == ahx_pkg::CFG_VARIANT);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;

    always_comb begin
        if (out_words_reg == '0) begin
            n_clamped = NW'(1);
        end else if ({1'b0, out_words_reg} > 7'(MAX_OUT_WORDS)) begin
            n_clamped = NW'(MAX_OUT_WORDS);
        end else begin
            n_clamped = NW'(out_words_reg);
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ahx_pkg::ST_LOAD: st_next = ahx_pkg::ST_INIT;
            ahx_pkg::ST_INIT,
            ahx_pkg::ST_ABS: begin
                if (rc_done) begin
                    st_next = ahx_pkg::ST_IDLE;
                end
            end
            ahx_pkg::ST_FIN,
            ahx_pkg::ST_SQZ: begin
                if (rc_done) begin
                    st_next = ahx_pkg::ST_OUT;
                end
            end
            ahx_pkg::ST_IDLE: begin
                if (q_valid) begin
                    st_next = q_head.final_blk ? ahx_pkg::ST_FIN : ahx_pkg::ST_ABS;
                end
            end
            ahx_pkg::ST_OUT: begin
                if (out_free) begin
                    st_next = is_last ? ahx_pkg::ST_INIT : ahx_pkg::ST_SQZ;
                end
            end
            default: st_next = ahx_pkg::ST_LOAD;
        endcase
        if (variant_wr) begin
            st_next = ahx_pkg::ST_LOAD;
        end
    end

    // The first round of every permutation runs in the cycle that starts it.
    always_comb begin
        round_in   = lanes_reg;
        rc_in      = rc_reg;
        lanes_next = lanes_reg;
        rc_next    = rc_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (st_reg)
            ahx_pkg::ST_LOAD: begin
                round_in   = ahx_pkg::ahx_iv(variant_reg);
                rc_in      = ahx_pkg::RC_FULL;
                lanes_next = round_out;
                rc_next    = ahx_pkg::RC_FULL - ahx_pkg::RC_STEP;
            end
            ahx_pkg::ST_INIT,
            ahx_pkg::ST_ABS,
            ahx_pkg::ST_FIN,
            ahx_pkg::ST_SQZ: begin
                lanes_next = round_out;
                rc_next    = rc_reg - ahx_pkg::RC_STEP;
            end
            ahx_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    round_in[0] = lanes_reg[0] ^ q_head.word;
                    rc_in       = q_head.final_blk ? ahx_pkg::RC_FULL
                                                   : ahx_pkg::ahx_rc_start(variant_reg);
                    lanes_next  = round_out;
                    rc_next     = rc_in - ahx_pkg::RC_STEP;
                    if (q_head.final_blk) begin
                        idx_next = '0;
                        n_next   = n_clamped;
                    end
                end
            end
            ahx_pkg::ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (is_last) begin
                        round_in = ahx_pkg::ahx_iv(variant_reg);
                        rc_in    = ahx_pkg::RC_FULL;
                    end else begin
                        rc_in    = ahx_pkg::ahx_rc_start(variant_reg);
                        idx_next = idx_reg + 1'b1;
                    end
                    lanes_next = round_out;
                    rc_next    = rc_in - ahx_pkg::RC_STEP;
                end
            end
            default: begin
                lanes_next = lanes_reg;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        rc_reg    <= rc_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        if (out_load) begin
            m_data_reg <= lanes_reg[0];
            m_last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ahx_pkg::ST_LOAD;
            m_valid_reg   <= 1'b0;
            variant_reg   <= ahx_pkg::VARIANT_RST;
            out_words_reg <= ahx_pkg::OUT_WORDS_RST;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            if (variant_wr) begin
                variant_reg <= cfg_wdata[1:0];
            end
            if (cfg_we && (cfg_index == ahx_pkg::CFG_OUT_WORDS)) begin
                out_words_reg <= cfg_wdata;
            end
        end
    end

    `AHX_ASSERT_NOW(a_pop_only_idle, aclk, aresetn, q_pop, (st_reg == ahx_pkg::ST_IDLE) && q_valid)
    `AHX_ASSERT_NOW(a_rc_in_range, aclk, aresetn,
        (st_reg == ahx_pkg::ST_ABS) || (st_reg == ahx_pkg::ST_FIN) || (st_reg == ahx_pkg::ST_SQZ),
        rc_reg >= ahx_pkg::RC_LAST)
    `AHX_ASSERT_NOW(a_idx_in_range, aclk, aresetn, st_reg == ahx_pkg::ST_OUT, idx_reg < n_reg)
    `AHX_ASSERT_NEXT(a_fin_to_out, aclk, aresetn,
        (st_reg == ahx_pkg::ST_FIN) && rc_done && !variant_wr, st_reg == ahx_pkg::ST_OUT)

endmodule
